// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define UDSC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("udsc assertion failed");

// Implication with the consequent checked in the cycle after the antecedent.
`define UDSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("udsc assertion failed");

`endif

// File: hdl/udsc_pkg.sv
// Package for the divisor set closure step: register indexes, controller states,
// datapath commands and status. Depends on nothing.
package udsc_pkg;

  localparam int MAX_MODULUS = 64;
  localparam int RED_STEPS   = 6;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_ALLOWED = 2'd1,
    REG_TARGET  = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    DST_R = 2'd0,
    DST_C = 2'd1,
    DST_J = 2'd2
  } red_dst_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_RESTART,
    OP_RED_R_START,
    OP_RED_C_START,
    OP_RED_J_START,
    OP_RED_STEP,
    OP_MUL_START,
    OP_MUL_STEP,
    OP_WALK_START,
    OP_WALK_STEP,
    OP_J_INIT,
    OP_J_HALVE,
    OP_J_SWAP,
    OP_J_FINISH,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RED_R,
    S_C_START,
    S_RED_C,
    S_M_START,
    S_MUL,
    S_W_START,
    S_WALK,
    S_J_INIT,
    S_J_TEST,
    S_J_MSTART,
    S_J_RED,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic red_last;
    logic walk_last;
    logic ja_zero;
    logic ja_even;
    logic mask_one;
  } dp_status_t;

endpackage

// File: hdl/udsc_if.sv
// Handshake channel interfaces for the divisor set closure step.
// Depends on nothing; each carries valid, ready and its payload.
interface udsc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [5:0] residue;
  modport source (output valid, mode, residue, input ready);
  modport sink (input valid, mode, residue, output ready);
endinterface

interface udsc_out_if;
  logic       valid;
  logic       ready;
  logic       miss;
  logic       miss_nonresidue;
  logic       pure_hit;
  logic       type_one_hit;
  logic [5:0] centre_value;
  logic       nonresidue_flag;
  modport source (output valid, miss, miss_nonresidue, pure_hit, type_one_hit,
                  centre_value, nonresidue_flag, input ready);
  modport sink (input valid, miss, miss_nonresidue, pure_hit, type_one_hit,
                centre_value, nonresidue_flag, output ready);
endinterface

interface udsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/udsc_datapath.sv
// Datapath of the divisor set closure step: configuration, state, a bit-serial
// reduction unit, the mask walk, the Jacobi registers and the result register. Uses udsc_pkg.
module udsc_datapath import udsc_pkg::*; #(
  parameter int MaxModulus = MAX_MODULUS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_mode_i,
  input  logic [5:0]  in_residue_i,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  output logic        miss_o,
  output logic        miss_nonresidue_o,
  output logic        pure_hit_o,
  output logic        type_one_hit_o,
  output logic [5:0]  centre_value_o,
  output logic        nonresidue_flag_o
);

  localparam int          IdxW = $clog2(MaxModulus);
  localparam logic [5:0]  KMax = 6'(MaxModulus - 1);

  logic [5:0]            modulus_q;
  logic [63:0]           allowed_q;
  logic [5:0]            target_q;
  logic                  mode_q;
  logic [5:0]            res_q, r_q, c_q;
  logic                  flag_q;
  logic [MaxModulus-1:0] mask_q, next_q, next_d, mask_set;
  logic [5:0]            sh_q, rem_q, red_m_q;
  red_dst_e              dst_q;
  logic [IdxW-1:0]       cnt_q;
  logic [5:0]            am_q, x_q;
  logic [5:0]            ja_q, jn_q;
  logic                  js_q;
  logic                  out_miss_q, out_mnr_q, out_pure_q, out_t1_q, out_flag_q;
  logic [5:0]            out_c_q;

  logic [5:0] k;
  logic [6:0] trial, dbl, add, x_sum;
  logic [5:0] red_rem, dbl_m, add_m, x_inc, t2;
  logic       red_last, walk_last, am_wrap, allow, t1hit, t2hit, miss;

  always_comb begin
    if (modulus_q < 6'd3) begin
      k = 6'd3;
    end else if (modulus_q > KMax) begin
      k = KMax;
    end else begin
      k = modulus_q;
    end
  end

  // One restoring step of the reduction unit.
  assign trial   = {rem_q, sh_q[5]};
  assign red_rem = (trial >= {1'b0, red_m_q}) ? 6'(trial - {1'b0, red_m_q}) : trial[5:0];

  // One double-and-add step of the modular product c * r.
  assign dbl   = {rem_q, 1'b0};
  assign dbl_m = (dbl >= {1'b0, k}) ? 6'(dbl - {1'b0, k}) : dbl[5:0];
  assign add   = {1'b0, dbl_m} + {1'b0, c_q};
  always_comb begin
    if (sh_q[5]) begin
      add_m = (add >= {1'b0, k}) ? 6'(add - {1'b0, k}) : add[5:0];
    end else begin
      add_m = dbl_m;
    end
  end

  // Walk: x tracks (a mod k) * r mod k as a runs upward.
  assign x_sum   = {1'b0, x_q} + {1'b0, r_q};
  assign x_inc   = (x_sum >= {1'b0, k}) ? 6'(x_sum - {1'b0, k}) : x_sum[5:0];
  assign am_wrap = ({1'b0, am_q} + 7'd1) == {1'b0, k};
  always_comb begin
    mask_set = '0;
    mask_set[x_q[IdxW-1:0]] = mask_q[cnt_q];
  end
  assign next_d = next_q | mask_set;

  assign red_last  = cnt_q == IdxW'(RED_STEPS - 1);
  assign walk_last = cnt_q == IdxW'(MaxModulus - 1);

  // Classification of the state after the step.
  assign t2    = (c_q == 6'd0) ? 6'd0 : 6'(k - c_q);
  assign allow = allowed_q[c_q];
  assign t1hit = ({1'b0, target_q} < 7'(MaxModulus)) && mask_q[target_q[IdxW-1:0]];
  assign t2hit = mask_q[t2[IdxW-1:0]];
  assign miss  = allow && !t1hit && !t2hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= 6'd3;
      allowed_q <= '0;
      target_q  <= 6'd2;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODULUS: modulus_q <= cfg_data_i[5:0];
        REG_ALLOWED: allowed_q <= cfg_data_i;
        REG_TARGET:  target_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaxModulus'(2);
      c_q    <= 6'd1;
      flag_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_RESTART: begin
          mask_q <= MaxModulus'(2);
          c_q    <= 6'd1;
          flag_q <= 1'b0;
        end
        OP_RED_STEP: begin
          if (red_last && dst_q == DST_C) begin
            c_q <= red_rem;
          end
        end
        OP_MUL_STEP: begin
          if (red_last) begin
            c_q <= add_m;
          end
        end
        OP_WALK_STEP: begin
          if (walk_last) begin
            mask_q <= next_d;
          end
        end
        OP_J_FINISH: begin
          if (jn_q == 6'd1 && js_q) begin
            flag_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q <= in_mode_i;
        res_q  <= in_residue_i;
      end
      OP_RED_R_START: begin
        sh_q <= res_q; red_m_q <= k; dst_q <= DST_R; rem_q <= '0; cnt_q <= '0;
      end
      OP_RED_C_START: begin
        sh_q <= c_q; red_m_q <= k; dst_q <= DST_C; rem_q <= '0; cnt_q <= '0;
      end
      OP_RED_J_START: begin
        sh_q <= ja_q; red_m_q <= jn_q; dst_q <= DST_J; rem_q <= '0; cnt_q <= '0;
      end
      OP_RED_STEP: begin
        rem_q <= red_rem;
        sh_q  <= {sh_q[4:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (red_last && dst_q == DST_R) begin
          r_q <= red_rem;
        end
        if (red_last && dst_q == DST_J) begin
          ja_q <= red_rem;
        end
      end
      OP_MUL_START: begin
        rem_q <= '0; sh_q <= r_q; cnt_q <= '0;
      end
      OP_MUL_STEP: begin
        rem_q <= add_m;
        sh_q  <= {sh_q[4:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
      end
      OP_WALK_START: begin
        next_q <= mask_q; am_q <= '0; x_q <= '0; cnt_q <= '0;
      end
      OP_WALK_STEP: begin
        next_q <= next_d;
        cnt_q  <= cnt_q + 1'b1;
        if (am_wrap) begin
          am_q <= '0;
          x_q  <= '0;
        end else begin
          am_q <= am_q + 6'd1;
          x_q  <= x_inc;
        end
      end
      OP_J_INIT: begin
        ja_q <= r_q; jn_q <= k; js_q <= 1'b0;
      end
      OP_J_HALVE: begin
        ja_q <= {1'b0, ja_q[5:1]};
        if (jn_q[2:0] == 3'd3 || jn_q[2:0] == 3'd5) begin
          js_q <= !js_q;
        end
      end
      OP_J_SWAP: begin
        ja_q <= jn_q;
        jn_q <= ja_q;
        if (jn_q[1:0] == 2'd3 && ja_q[1:0] == 2'd3) begin
          js_q <= !js_q;
        end
      end
      OP_EMIT: begin
        out_miss_q <= miss;
        out_mnr_q  <= miss && flag_q;
        out_pure_q <= allow && !miss && !flag_q;
        out_t1_q   <= t1hit;
        out_c_q    <= c_q;
        out_flag_q <= flag_q;
      end
      default: ;
    endcase
  end

  assign status_o.mode      = mode_q;
  assign status_o.red_last  = red_last;
  assign status_o.walk_last = walk_last;
  assign status_o.ja_zero   = ja_q == 6'd0;
  assign status_o.ja_even   = !ja_q[0];
  assign status_o.mask_one  = mask_q[1];

  assign miss_o            = out_miss_q;
  assign miss_nonresidue_o = out_mnr_q;
  assign pure_hit_o        = out_pure_q;
  assign type_one_hit_o    = out_t1_q;
  assign centre_value_o    = out_c_q;
  assign nonresidue_flag_o = out_flag_q;

endmodule

// File: hdl/udsc_ctrl.sv
// Controller of the divisor set closure step: sequences one request through
// the datapath and owns the input ready and output valid. Uses udsc_pkg.
module udsc_ctrl import udsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: state_d = status_i.mode ? S_RED_R : S_FIN;
      S_RED_R:    if (status_i.red_last) state_d = S_C_START;
      S_C_START:  state_d = S_RED_C;
      S_RED_C:    if (status_i.red_last) state_d = S_M_START;
      S_M_START:  state_d = S_MUL;
      S_MUL:      if (status_i.red_last) state_d = S_W_START;
      S_W_START:  state_d = S_WALK;
      S_WALK:     if (status_i.walk_last) state_d = S_J_INIT;
      S_J_INIT:   state_d = S_J_TEST;
      S_J_TEST: begin
        if (status_i.ja_zero) begin
          state_d = S_FIN;
        end else if (!status_i.ja_even) begin
          state_d = S_J_MSTART;
        end
      end
      S_J_MSTART: state_d = S_J_RED;
      S_J_RED:    if (status_i.red_last) state_d = S_J_TEST;
      S_FIN:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = OP_IDLE;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) cmd_o.op = OP_LOAD;
      S_DISPATCH: cmd_o.op = status_i.mode ? OP_RED_R_START : OP_RESTART;
      S_RED_R:    cmd_o.op = OP_RED_STEP;
      S_C_START:  cmd_o.op = OP_RED_C_START;
      S_RED_C:    cmd_o.op = OP_RED_STEP;
      S_M_START:  cmd_o.op = OP_MUL_START;
      S_MUL:      cmd_o.op = OP_MUL_STEP;
      S_W_START:  cmd_o.op = OP_WALK_START;
      S_WALK:     cmd_o.op = OP_WALK_STEP;
      S_J_INIT:   cmd_o.op = OP_J_INIT;
      S_J_TEST: begin
        if (status_i.ja_zero) begin
          cmd_o.op = OP_J_FINISH;
        end else if (status_i.ja_even) begin
          cmd_o.op = OP_J_HALVE;
        end else begin
          cmd_o.op = OP_J_SWAP;
        end
      end
      S_J_MSTART: cmd_o.op = OP_RED_J_START;
      S_J_RED:    cmd_o.op = OP_RED_STEP;
      S_FIN: begin
        if (out_free) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/unit_divisor_set_closure_step.sv
// Top level of the divisor set closure step.
// Depends on udsc_pkg, the channel interfaces, udsc_ctrl and udsc_datapath.
//
// Usage: the block keeps a mask of divisor residues mod k, the product residue c
// and a non-residue flag. Each request on in_i either restarts this state
// (mode 0) or consumes one prime residue (mode 1). Every request produces
// exactly one result on out_o that classifies the new state.
// Configuration requests arrive on cfg_i, which is always ready; they should
// only be issued while no request is in flight.
// A restart goes from dispatch straight to the final state, where the result
// register is loaded. A consume request reduces r and c, forms the product,
// walks the mask and then runs the Jacobi symbol loop, which halves, or swaps
// and reduces, until the numerator is zero, and then finishes. The mask
// walk visits one mask bit per cycle, and every modular reduction and the
// product go through one bit per cycle in the shared reduction unit.
// One request is worked on at a time; in_i.ready is high only while idle.
// The result register lets a new request be accepted while a finished result
// still waits; if the receiver stalls, the next result holds in the final
// state until the register frees up.
// Reset sets the mask to the residue one alone, c to 1, the flag to 0, and the
// registers to modulus 3, no allowed centres and Type I target 2.
`include "assert_macros.svh"

module unit_divisor_set_closure_step import udsc_pkg::*; #(
  parameter int MaxModulus = MAX_MODULUS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  udsc_cfg_if.sink  cfg_i,
  udsc_in_if.sink   in_i,
  udsc_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers never back-pressure.
  assign cfg_i.ready = 1'b1;

  udsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  udsc_datapath #(
    .MaxModulus (MaxModulus)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .in_mode_i         (in_i.mode),
    .in_residue_i      (in_i.residue),
    .cmd_i             (cmd),
    .status_o          (status),
    .miss_o            (out_o.miss),
    .miss_nonresidue_o (out_o.miss_nonresidue),
    .pure_hit_o        (out_o.pure_hit),
    .type_one_hit_o    (out_o.type_one_hit),
    .centre_value_o    (out_o.centre_value),
    .nonresidue_flag_o (out_o.nonresidue_flag)
  );

  // An accepted request keeps the block busy in the next cycle.
  `UDSC_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  // A new result only appears while a request is being worked on.
  `UDSC_ASSERT(a_result_from_work, !$rose(out_o.valid) || $past(!in_i.ready))
  // The residue one always stays in the divisor set.
  `UDSC_ASSERT(a_one_in_mask, status.mask_one)

endmodule
